### sv/cfsa_pkg.sv
// ----------------------------------------------------------------------------
// cfsa_pkg
// Shared types and constants of the circular free-slot allocator: item
// layouts of both channels, field widths and request codes.
// ----------------------------------------------------------------------------
package cfsa_pkg;

    localparam int SLOT_W = 10;
    localparam int CNT_W  = 11;

    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

    // Request codes
    localparam logic ACT_ENTER = 1'b0;
    localparam logic ACT_EXIT  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] slot;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        logic              full_res;
    } t_out_item;

endpackage

### sv/circular_free_slot_allocator.sv
// ----------------------------------------------------------------------------
// circular_free_slot_allocator
// Grants the wanted slot if free, else the next free slot upward with
// wrap-around, and frees slots on exit, using a tree of free marks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_item): action 0 asks for a
//   slot near i_in_item.slot, action 1 frees that slot. Each enter gives one
//   item on the output channel (o_out_valid/i_out_ready, o_out_item): the
//   granted slot, or full_res=1 with slot 0. An exit gives no item.
//   Config channel (i_cfg_valid/o_cfg_ready, i_cfg_data) sets the slot count;
//   write it only while no request is in flight.
//   One request at a time: a node stepper walks the tree through a single
//   read and write port, one node per cycle. An exit updates from the leaf
//   up to the root. An enter checks the wanted slot and, when it is used,
//   searches by climbing, descending and wrapping, then updates from the
//   leaf up to the root.
//   Reset clears the count to 1024 and then sweeps every tree node, with
//   o_in_ready low. A finished result sits in an output register, so the
//   next request is taken while it waits; a further enter holds in its
//   last step until the receiver takes it.
// ----------------------------------------------------------------------------
module circular_free_slot_allocator
    import cfsa_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    localparam int LEVELS = $clog2(SLOTS);
    localparam int NW     = LEVELS + 1;
    localparam int CW     = (NW > CNT_W) ? NW : CNT_W;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
    localparam logic [NW-1:0] ROOT    = NW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CLIMB,
        S_DOWN,
        S_UPD_LEAF,
        S_UPD_UP,
        S_OUT
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_slot_count;
    logic [NW-1:0]    r_node, n_node;
    logic [CW-1:0]    r_want, n_want;
    logic [CW-1:0]    r_bound, n_bound;
    logic             r_second, n_second;
    logic             r_val, n_val;
    logic             r_enter, n_enter;
    t_out_item        r_res, n_res;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic [NW-1:0]    rd_addr;
    logic             rd_free;
    logic             wr_en;
    logic [NW-1:0]    wr_addr;
    logic             wr_free;
    logic             clr_busy;

    logic [CW-1:0]    cnt;
    logic [CW-1:0]    want_cur;
    logic [CW-1:0]    top_b;
    logic             out_load;

    function automatic logic [NW-1:0] leaf_of(input logic [CW-1:0] s);
        return {1'b1, s[LEVELS-1:0]};
    endfunction

    function automatic logic [NW-1:0] left_of(input logic [NW-1:0] n);
        return {n[NW-2:0], 1'b0};
    endfunction

    cfsa_tree #(
        .LEVELS (LEVELS)
    ) u_tree (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_free (rd_free),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_free (wr_free),
        .o_busy    (clr_busy)
    );

    // Clamp the count to the slots that exist
    always_comb begin
        cnt = (CW'(r_slot_count) > SLOTS_C) ? SLOTS_C : CW'(r_slot_count);
    end

    assign want_cur   = (r_state == S_IDLE) ? CW'(i_in_item.slot) : r_want;
    assign top_b      = (want_cur < cnt) ? want_cur : cnt;
    assign o_in_ready = (r_state == S_IDLE) && !clr_busy;
    assign o_cfg_ready = 1'b1;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Sequencer: node stepper over the tree
    always_comb begin
        logic          go_found;
        logic          go_none;
        logic          go_b;
        logic          go_full;
        logic [NW-1:0] found_node;
        logic [NW-1:0] pick;
        logic [NW-1:0] par;
        logic [CW-1:0] found_idx;
        logic          exhausted;

        n_state    = r_state;
        n_node     = r_node;
        n_want     = r_want;
        n_bound    = r_bound;
        n_second   = r_second;
        n_val      = r_val;
        n_enter    = r_enter;
        n_res      = r_res;
        rd_addr    = ROOT;
        wr_en      = 1'b0;
        wr_addr    = r_node;
        wr_free    = r_val;
        go_found   = 1'b0;
        go_none    = 1'b0;
        go_b       = 1'b0;
        go_full    = 1'b0;
        found_node = r_node;
        pick       = rd_free ? r_node : (r_node | ROOT);
        par        = r_node >> 1;
        exhausted  = (r_state == S_CLIMB) || !rd_free;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_want = want_cur;
                    if (i_in_item.action == ACT_EXIT) begin
                        if (want_cur < cnt) begin
                            n_node  = leaf_of(want_cur);
                            n_val   = 1'b1;
                            n_enter = 1'b0;
                            n_state = S_UPD_LEAF;
                        end
                    end else begin
                        n_enter = 1'b1;
                        if (want_cur < cnt) begin
                            n_bound  = cnt;
                            n_second = 1'b0;
                            n_node   = leaf_of(want_cur);
                            rd_addr  = leaf_of(want_cur);
                            n_state  = S_CHECK;
                        end else begin
                            go_b = 1'b1;
                        end
                    end
                end
            end
            S_CHECK, S_CLIMB: begin
                if (!exhausted) begin
                    // Subtree has a free slot: descend or stop at a leaf
                    if (r_node[LEVELS]) begin
                        go_found   = 1'b1;
                        found_node = r_node;
                    end else begin
                        rd_addr = left_of(r_node);
                        n_node  = left_of(r_node);
                        n_state = S_DOWN;
                    end
                end else if (r_node == ROOT) begin
                    go_none = 1'b1;
                end else if (r_node[0]) begin
                    // Right child used up: its parent is used up too
                    n_node  = par;
                    n_state = S_CLIMB;
                end else begin
                    // Left child used up: try the right sibling
                    n_node  = r_node | ROOT;
                    rd_addr = r_node | ROOT;
                    n_state = S_CHECK;
                end
            end
            S_DOWN: begin
                if (pick[LEVELS]) begin
                    go_found   = 1'b1;
                    found_node = pick;
                end else begin
                    rd_addr = left_of(pick);
                    n_node  = left_of(pick);
                end
            end
            S_UPD_LEAF: begin
                wr_en   = 1'b1;
                wr_addr = r_node;
                wr_free = r_val;
                rd_addr = r_node ^ ROOT;
                n_state = S_UPD_UP;
            end
            S_UPD_UP: begin
                // Parent is free if either child is
                wr_en   = 1'b1;
                wr_addr = par;
                wr_free = r_val | rd_free;
                n_val   = r_val | rd_free;
                n_node  = par;
                rd_addr = par ^ ROOT;
                if (par == ROOT) begin
                    n_state = r_enter ? S_OUT : S_IDLE;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Resolve a finished search
        found_idx = CW'(found_node[LEVELS-1:0]);
        if (go_found && (found_idx < r_bound)) begin
            n_node  = found_node;
            n_val   = 1'b0;
            n_res   = '{granted_slot: found_idx[SLOT_W-1:0], full_res: 1'b0};
            n_state = S_UPD_LEAF;
        end else if (go_found || go_none) begin
            if (!r_second) begin
                go_b = 1'b1;
            end else begin
                go_full = 1'b1;
            end
        end

        // Wrap: lowest free slot below the wanted one
        if (go_b) begin
            if (top_b == '0) begin
                go_full = 1'b1;
            end else begin
                n_bound  = top_b;
                n_second = 1'b1;
                n_node   = ROOT;
                rd_addr  = ROOT;
                n_state  = S_CHECK;
            end
        end

        if (go_full) begin
            n_res   = '{granted_slot: '0, full_res: 1'b1};
            n_state = S_OUT;
        end
    end

    // State, config register and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_count <= CNT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_slot_count <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_node   <= n_node;
        r_want   <= n_want;
        r_bound  <= n_bound;
        r_second <= n_second;
        r_val    <= n_val;
        r_enter  <= n_enter;
        r_res    <= n_res;
        if (out_load) begin
            r_out_item <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    // No request is taken while the tree is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !o_in_ready)
        else $error("request accepted during tree clearing");

    // Tree update never reads the node it writes
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wr_addr != rd_addr))
        else $error("tree read and write at the same node");

    // Walk never leaves the tree
    a_node_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK || r_state == S_CLIMB || r_state == S_DOWN ||
         r_state == S_UPD_LEAF || r_state == S_UPD_UP) |-> (r_node != '0))
        else $error("tree walk at node zero");

    // A full answer carries slot zero
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.full_res) |-> (o_out_item.granted_slot == '0))
        else $error("full result with nonzero slot");
`endif

endmodule

### sv/cfsa_tree.sv
// ----------------------------------------------------------------------------
// cfsa_tree
// Free-mark tree storage: one bit per tree node (root at 1, leaves at
// 2**LEVELS + slot), one write and one registered read per cycle. After
// reset a sweep sets every node to free, one address per cycle.
// ----------------------------------------------------------------------------
module cfsa_tree #(
    parameter int LEVELS = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [LEVELS:0] i_rd_addr,
    output logic            o_rd_free,
    input  logic            i_wr_en,
    input  logic [LEVELS:0] i_wr_addr,
    input  logic            i_wr_free,
    output logic            o_busy
);

    localparam int DEPTH = 2 ** (LEVELS + 1);

    logic            mem [DEPTH];
    logic            r_rd_free;
    logic            r_clr_busy;
    logic [LEVELS:0] r_clr_addr;

    logic            wr_en;
    logic [LEVELS:0] wr_addr;
    logic            wr_free;

    // Sweep has the write port while it runs
    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_free = 1'b1;
        end else begin
            wr_en   = i_wr_en;
            wr_addr = i_wr_addr;
            wr_free = i_wr_free;
        end
    end

    // Advance the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_free;
        end
        r_rd_free <= mem[i_rd_addr];
    end

    assign o_rd_free = r_rd_free;
    assign o_busy    = r_clr_busy;

endmodule
